[src/min_jerk_pose_interpolator_assert.svh]
// Assertion macros for the pose interpolator. They assume aclk and aresetn are in scope.
`ifndef MIN_JERK_POSE_INTERPOLATOR_ASSERT_SVH
`define MIN_JERK_POSE_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MJPI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pose interpolator check failed");

// The consequent must hold in the cycle after the antecedent.
`define MJPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pose interpolator check failed");

`endif

[src/mjpi_pkg.sv]
package mjpi_pkg;

    localparam int DEF_MAX_STEPS = 63;

    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DS_ARG_W = 64;
    localparam int DS_RES_W = 32;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam logic [2:0] CFG_START_POS  = 3'd0;
    localparam logic [2:0] CFG_TARGET_POS = 3'd1;
    localparam logic [2:0] CFG_START_ORI  = 3'd2;
    localparam logic [2:0] CFG_TARGET_ORI = 3'd3;
    localparam logic [2:0] CFG_STEP_INT   = 3'd4;
    localparam logic [2:0] CFG_HORIZ_RCP  = 3'd5;
    localparam logic [2:0] CFG_STEP_CNT   = 3'd6;
    localparam logic [2:0] CFG_MODE       = 3'd7;

    localparam int MODE_MINJERK_BIT = 0;
    localparam int MODE_ORIENT_BIT  = 1;

    localparam logic [63:0] RST_ORI       = 64'd16384;
    localparam logic [19:0] RST_STEP_INT  = 20'd655;
    localparam logic [31:0] RST_HORIZ_RCP = 32'd65536;
    localparam logic [5:0]  RST_STEP_CNT  = 6'd10;
    localparam logic [1:0]  RST_MODE      = 2'd1;

    typedef logic signed [32:0] q30_t;
    typedef logic signed [33:0] qsum_t;
    typedef logic signed [MUL_W-1:0] mul_op_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } ds_req_t;

    function automatic logic signed [15:0] round_q14(input q30_t c);
        logic signed [33:0] sum;
        logic signed [17:0] sh;
        sum = 34'(c) + 34'sd32768;
        sh = 18'(sum >>> 16);
        if (sh > 18'sd16384) begin
            return 16'sd16384;
        end else if (sh < -18'sd16384) begin
            return -16'sd16384;
        end
        return 16'(sh);
    endfunction

endpackage

[src/mjpi_mul.sv]
module mjpi_mul (
    input  logic             aclk,
    input  mjpi_pkg::mul_op_t op_a,
    input  mjpi_pkg::mul_op_t op_b,
    output mjpi_pkg::prod_t   prod
);

    mjpi_pkg::prod_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[src/mjpi_divsqrt.sv]
module mjpi_divsqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mjpi_pkg::ds_req_t               req,
    input  logic [mjpi_pkg::DS_ARG_W-1:0]   operand,
    input  logic [mjpi_pkg::DS_RES_W-1:0]   divisor,
    output logic                            done,
    output logic [mjpi_pkg::DS_RES_W-1:0]   result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        sqrt_reg;
    logic [34:0] rem_reg;
    logic [63:0] num_reg;
    logic [31:0] root_reg;
    logic [31:0] div_reg;

    logic [34:0] r1;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    always_comb begin
        if (sqrt_reg) begin
            r1    = {rem_reg[32:0], num_reg[63:62]};
            trial = {1'b0, root_reg, 2'b01};
        end else begin
            r1    = {rem_reg[33:0], num_reg[63]};
            trial = {3'b000, div_reg};
        end
        ge   = (r1 >= trial);
        diff = r1 - trial;
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            sqrt_reg <= req.sqrt_mode;
            root_reg <= 32'd0;
            div_reg  <= divisor;
            if (req.sqrt_mode) begin
                rem_reg <= 35'd0;
                num_reg <= operand;
            end else begin
                rem_reg <= {3'b000, operand[63:32]};
                num_reg <= {operand[31:0], 32'd0};
            end
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff : r1;
            root_reg <= {root_reg[30:0], ge};
            num_reg  <= sqrt_reg ? {num_reg[61:0], 2'b00} : {num_reg[62:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = root_reg;

endmodule

[src/min_jerk_pose_interpolator.sv]
// Channel   | Direction | Handshake            | Payload
// s_        | in        | s_valid / s_ready    | s_obs_time
// m_        | out       | m_valid / m_ready    | m_sample_time, m_pos_*, m_quat_*, m_last_pose
// cfg_      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction on s_ yields N+1 poses; s_ready is low until the last one is taken.
// With orientation the setup and each pose are paced by the shared divide and square-root
// unit (up to five operations per normalization, up to nine normalizations per pose).
// Reset is synchronous on aresetn and restores the configuration and sequencer registers.
// A stalled m_ready holds the pose and the sequencer; cfg_ready is always high.
module min_jerk_pose_interpolator #(
    parameter int MAX_STEPS = mjpi_pkg::DEF_MAX_STEPS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_obs_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_sample_time,
    output logic signed [19:0] m_pos_x,
    output logic signed [19:0] m_pos_y,
    output logic signed [19:0] m_pos_z,
    output logic signed [15:0] m_quat_w,
    output logic signed [15:0] m_quat_x,
    output logic signed [15:0] m_quat_y,
    output logic signed [15:0] m_quat_z,
    output logic               m_last_pose,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam int K_W = $clog2(MAX_STEPS + 1);
    localparam logic [36:0] P_BASE = 37'd10737418240;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_SETUP     = 5'd1;
    localparam logic [4:0] ST_Q0_DONE   = 5'd2;
    localparam logic [4:0] ST_Q1_DONE   = 5'd3;
    localparam logic [4:0] ST_DOT_MUL   = 5'd4;
    localparam logic [4:0] ST_DOT_ACC   = 5'd5;
    localparam logic [4:0] ST_DOT_FIX   = 5'd6;
    localparam logic [4:0] ST_TAU       = 5'd7;
    localparam logic [4:0] ST_TAU_TAKE  = 5'd8;
    localparam logic [4:0] ST_SCALE     = 5'd9;
    localparam logic [4:0] ST_SC_T2     = 5'd10;
    localparam logic [4:0] ST_SC_T3     = 5'd11;
    localparam logic [4:0] ST_SC_S      = 5'd12;
    localparam logic [4:0] ST_POS_MUL   = 5'd13;
    localparam logic [4:0] ST_POS_TAKE  = 5'd14;
    localparam logic [4:0] ST_QSEL      = 5'd15;
    localparam logic [4:0] ST_BIS       = 5'd16;
    localparam logic [4:0] ST_BIS_DONE  = 5'd17;
    localparam logic [4:0] ST_LERP_MUL  = 5'd18;
    localparam logic [4:0] ST_LERP_TAKE = 5'd19;
    localparam logic [4:0] ST_R_DONE    = 5'd20;
    localparam logic [4:0] ST_EMIT      = 5'd21;
    localparam logic [4:0] ST_N_SQ_MUL  = 5'd22;
    localparam logic [4:0] ST_N_SQ_ACC  = 5'd23;
    localparam logic [4:0] ST_N_SQRT    = 5'd24;
    localparam logic [4:0] ST_N_SQRT_W  = 5'd25;
    localparam logic [4:0] ST_N_DIV     = 5'd26;
    localparam logic [4:0] ST_N_DIV_W   = 5'd27;

    logic [59:0] start_pos_reg, target_pos_reg;
    logic [63:0] start_ori_reg, target_ori_reg;
    logic [19:0] step_int_reg;
    logic [31:0] horiz_rcp_reg;
    logic [5:0]  step_cnt_reg;
    logic [1:0]  mode_reg;

    logic [4:0]  state_reg, state_next;
    logic [4:0]  ret_reg, ret_next;
    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  step_reg, step_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [K_W-1:0] n_reg, n_next;
    logic [32:0] tk_reg, tk_next;
    logic [31:0] origin_reg, origin_next;
    logic        origin_valid_reg, origin_valid_next;
    logic [30:0] tau_reg, tau_next;
    logic [30:0] t2_reg, t2_next;
    logic [30:0] s_reg, s_next;
    logic signed [63:0] dot_reg, dot_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] nrm_reg, nrm_next;

    mjpi_pkg::qsum_t nv_reg [4];
    mjpi_pkg::qsum_t nv_next [4];
    mjpi_pkg::q30_t  nq_reg [4];
    mjpi_pkg::q30_t  nq_next [4];
    mjpi_pkg::q30_t  q0_reg [4];
    mjpi_pkg::q30_t  q0_next [4];
    mjpi_pkg::q30_t  q1_reg [4];
    mjpi_pkg::q30_t  q1_next [4];
    mjpi_pkg::q30_t  a_reg [4];
    mjpi_pkg::q30_t  a_next [4];
    mjpi_pkg::q30_t  b_reg [4];
    mjpi_pkg::q30_t  b_next [4];
    logic signed [19:0] pos_reg [3];
    logic signed [19:0] pos_next [3];
    logic signed [15:0] qo_reg [4];
    logic signed [15:0] qo_next [4];

    logic [K_W-1:0]     n_clamp;
    logic signed [19:0] p0 [3];
    logic signed [20:0] dp [3];
    logic signed [33:0] el;
    logic [30:0]        t2_w;
    logic [30:0]        t3_w;
    logic [36:0]        p_w;
    logic [39:0]        s_full;

    mjpi_pkg::mul_op_t mul_a, mul_b;
    mjpi_pkg::prod_t   prod;
    mjpi_pkg::prod_t   pos_rnd;
    mjpi_pkg::prod_t   lerp_sh;
    logic signed [22:0] pos_sum;
    logic [33:0]        nv_mag;
    logic [7:0]         sbits;

    mjpi_pkg::ds_req_t ds_req;
    logic [63:0]       ds_operand;
    logic              ds_done;
    logic [31:0]       ds_result;

    function automatic mjpi_pkg::qsum_t unpack_q(input logic [15:0] x);
        return {{4{x[15]}}, x, 14'd0};
    endfunction

    function automatic logic [33:0] mag34(input mjpi_pkg::qsum_t v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    mjpi_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    mjpi_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ds_req),
        .operand (ds_operand),
        .divisor (nrm_reg),
        .done    (ds_done),
        .result  (ds_result)
    );

    always_comb begin
        if (step_cnt_reg == 6'd0) begin
            n_clamp = K_W'(1);
        end else if (32'(step_cnt_reg) > 32'(MAX_STEPS)) begin
            n_clamp = K_W'(MAX_STEPS);
        end else begin
            n_clamp = K_W'(step_cnt_reg);
        end
        for (int i = 0; i < 3; i++) begin
            p0[i] = start_pos_reg[20*i +: 20];
            dp[i] = 21'($signed(target_pos_reg[20*i +: 20])) - 21'(p0[i]);
        end
        el     = $signed({1'b0, tk_reg}) - $signed({2'b00, origin_reg});
        t2_w   = prod[60:30];
        t3_w   = prod[60:30];
        p_w    = P_BASE - ({6'd0, tau_reg} << 4) + {6'd0, tau_reg}
               + ({6'd0, t2_reg} << 2) + ({6'd0, t2_reg} << 1);
        s_full = prod[69:30];
        pos_rnd = (prod + mjpi_pkg::prod_t'(70'sd536870912)) >>> 30;
        lerp_sh = prod >>> 22;
        pos_sum = 23'(p0[idx_reg]) + 23'($signed(pos_rnd[21:0]));
        nv_mag  = mag34(nv_reg[idx_reg]);
        sbits   = s_reg[29:22];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DOT_MUL: begin
                mul_a = mjpi_pkg::MUL_W'(q0_reg[idx_reg]);
                mul_b = mjpi_pkg::MUL_W'(q1_reg[idx_reg]);
            end
            ST_TAU: begin
                mul_a = {3'b000, el[31:0]};
                mul_b = {3'b000, horiz_rcp_reg};
            end
            ST_SCALE: begin
                mul_a = {4'd0, tau_reg};
                mul_b = {4'd0, tau_reg};
            end
            ST_SC_T2: begin
                mul_a = {4'd0, t2_w};
                mul_b = {4'd0, tau_reg};
            end
            ST_SC_T3: begin
                mul_a = {4'd0, t3_w};
                mul_b = p_w[36] ? '0 : mjpi_pkg::MUL_W'(p_w);
            end
            ST_POS_MUL: begin
                mul_a = {4'd0, s_reg};
                mul_b = mjpi_pkg::MUL_W'(dp[idx_reg]);
            end
            ST_LERP_MUL: begin
                mul_a = mjpi_pkg::MUL_W'(34'(b_reg[idx_reg]) - 34'(a_reg[idx_reg]));
                mul_b = {13'd0, s_reg[21:0]};
            end
            ST_N_SQ_MUL: begin
                mul_a = {1'b0, nv_mag};
                mul_b = {1'b0, nv_mag};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        ret_next          = ret_reg;
        idx_next          = idx_reg;
        step_next         = step_reg;
        k_next            = k_reg;
        n_next            = n_reg;
        tk_next           = tk_reg;
        origin_next       = origin_reg;
        origin_valid_next = origin_valid_reg;
        tau_next          = tau_reg;
        t2_next           = t2_reg;
        s_next            = s_reg;
        dot_next          = dot_reg;
        acc_next          = acc_reg;
        nrm_next          = nrm_reg;
        nv_next           = nv_reg;
        nq_next           = nq_reg;
        q0_next           = q0_reg;
        q1_next           = q1_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        pos_next          = pos_reg;
        qo_next           = qo_reg;
        ds_req            = '0;
        ds_operand        = acc_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    tk_next = {1'b0, s_obs_time};
                    k_next  = '0;
                    n_next  = n_clamp;
                    if (!origin_valid_reg) begin
                        origin_next       = s_obs_time;
                        origin_valid_next = 1'b1;
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (mode_reg[mjpi_pkg::MODE_ORIENT_BIT]) begin
                    for (int i = 0; i < 4; i++) begin
                        nv_next[i] = unpack_q(start_ori_reg[16*i +: 16]);
                    end
                    ret_next   = ST_Q0_DONE;
                    idx_next   = 2'd0;
                    acc_next   = '0;
                    state_next = ST_N_SQ_MUL;
                end else begin
                    state_next = ST_TAU;
                end
            end
            ST_Q0_DONE: begin
                q0_next = nq_reg;
                for (int i = 0; i < 4; i++) begin
                    nv_next[i] = unpack_q(target_ori_reg[16*i +: 16]);
                end
                ret_next   = ST_Q1_DONE;
                idx_next   = 2'd0;
                acc_next   = '0;
                state_next = ST_N_SQ_MUL;
            end
            ST_Q1_DONE: begin
                q1_next    = nq_reg;
                idx_next   = 2'd0;
                dot_next   = '0;
                state_next = ST_DOT_MUL;
            end
            ST_DOT_MUL: begin
                state_next = ST_DOT_ACC;
            end
            ST_DOT_ACC: begin
                dot_next = dot_reg + $signed(prod[63:0]);
                if (idx_reg == 2'd3) begin
                    state_next = ST_DOT_FIX;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DOT_MUL;
                end
            end
            ST_DOT_FIX: begin
                if (dot_reg[63]) begin
                    for (int i = 0; i < 4; i++) begin
                        q1_next[i] = -q1_reg[i];
                    end
                end
                state_next = ST_TAU;
            end
            ST_TAU: begin
                if (el[33] || el == 34'sd0 || horiz_rcp_reg == 32'd0) begin
                    tau_next   = '0;
                    state_next = ST_SCALE;
                end else if (el[32]) begin
                    tau_next   = mjpi_pkg::Q30_ONE;
                    state_next = ST_SCALE;
                end else begin
                    state_next = ST_TAU_TAKE;
                end
            end
            ST_TAU_TAKE: begin
                if (prod[63:2] > 62'(mjpi_pkg::Q30_ONE)) begin
                    tau_next = mjpi_pkg::Q30_ONE;
                end else begin
                    tau_next = prod[32:2];
                end
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (mode_reg[mjpi_pkg::MODE_MINJERK_BIT]) begin
                    state_next = ST_SC_T2;
                end else begin
                    s_next     = tau_reg;
                    idx_next   = 2'd0;
                    state_next = ST_POS_MUL;
                end
            end
            ST_SC_T2: begin
                t2_next    = t2_w;
                state_next = ST_SC_T3;
            end
            ST_SC_T3: begin
                state_next = ST_SC_S;
            end
            ST_SC_S: begin
                if (s_full > 40'(mjpi_pkg::Q30_ONE)) begin
                    s_next = mjpi_pkg::Q30_ONE;
                end else begin
                    s_next = s_full[30:0];
                end
                idx_next   = 2'd0;
                state_next = ST_POS_MUL;
            end
            ST_POS_MUL: begin
                state_next = ST_POS_TAKE;
            end
            ST_POS_TAKE: begin
                if (pos_sum > 23'sd524287) begin
                    pos_next[idx_reg] = 20'sd524287;
                end else if (pos_sum < -23'sd524288) begin
                    pos_next[idx_reg] = -20'sd524288;
                end else begin
                    pos_next[idx_reg] = 20'(pos_sum);
                end
                if (idx_reg == 2'd2) begin
                    state_next = ST_QSEL;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_POS_MUL;
                end
            end
            ST_QSEL: begin
                if (!mode_reg[mjpi_pkg::MODE_ORIENT_BIT]) begin
                    for (int i = 0; i < 4; i++) begin
                        qo_next[i] = start_ori_reg[16*i +: 16];
                    end
                    state_next = ST_EMIT;
                end else if (s_reg >= mjpi_pkg::Q30_ONE) begin
                    for (int i = 0; i < 4; i++) begin
                        qo_next[i] = mjpi_pkg::round_q14(q1_reg[i]);
                    end
                    state_next = ST_EMIT;
                end else begin
                    a_next     = q0_reg;
                    b_next     = q1_reg;
                    step_next  = 3'd0;
                    state_next = ST_BIS;
                end
            end
            ST_BIS: begin
                for (int i = 0; i < 4; i++) begin
                    nv_next[i] = 34'(a_reg[i]) + 34'(b_reg[i]);
                end
                ret_next   = ST_BIS_DONE;
                idx_next   = 2'd0;
                acc_next   = '0;
                state_next = ST_N_SQ_MUL;
            end
            ST_BIS_DONE: begin
                if (sbits[3'd7 - step_reg]) begin
                    a_next = nq_reg;
                end else begin
                    b_next = nq_reg;
                end
                if (step_reg == 3'd7) begin
                    idx_next   = 2'd0;
                    state_next = ST_LERP_MUL;
                end else begin
                    step_next  = step_reg + 3'd1;
                    state_next = ST_BIS;
                end
            end
            ST_LERP_MUL: begin
                state_next = ST_LERP_TAKE;
            end
            ST_LERP_TAKE: begin
                nv_next[idx_reg] = 34'(a_reg[idx_reg]) + 34'(lerp_sh[33:0]);
                if (idx_reg == 2'd3) begin
                    ret_next   = ST_R_DONE;
                    idx_next   = 2'd0;
                    acc_next   = '0;
                    state_next = ST_N_SQ_MUL;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_LERP_MUL;
                end
            end
            ST_R_DONE: begin
                for (int i = 0; i < 4; i++) begin
                    qo_next[i] = mjpi_pkg::round_q14(nq_reg[i]);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (k_reg == n_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + K_W'(1);
                        tk_next    = tk_reg + {13'd0, step_int_reg};
                        state_next = ST_TAU;
                    end
                end
            end
            ST_N_SQ_MUL: begin
                state_next = ST_N_SQ_ACC;
            end
            ST_N_SQ_ACC: begin
                acc_next = acc_reg + prod[63:0];
                if (idx_reg == 2'd3) begin
                    state_next = ST_N_SQRT;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_N_SQ_MUL;
                end
            end
            ST_N_SQRT: begin
                ds_req.start     = 1'b1;
                ds_req.sqrt_mode = 1'b1;
                ds_operand       = acc_reg;
                state_next       = ST_N_SQRT_W;
            end
            ST_N_SQRT_W: begin
                if (ds_done) begin
                    nrm_next = ds_result;
                    if (ds_result == 32'd0) begin
                        nq_next[0] = 33'(mjpi_pkg::Q30_ONE);
                        nq_next[1] = '0;
                        nq_next[2] = '0;
                        nq_next[3] = '0;
                        state_next = ret_reg;
                    end else begin
                        idx_next   = 2'd0;
                        state_next = ST_N_DIV;
                    end
                end
            end
            ST_N_DIV: begin
                ds_req.start     = 1'b1;
                ds_req.sqrt_mode = 1'b0;
                ds_operand       = {nv_mag, 30'd0} + {33'd0, nrm_reg[31:1]};
                state_next       = ST_N_DIV_W;
            end
            ST_N_DIV_W: begin
                if (ds_done) begin
                    if (nv_reg[idx_reg][33]) begin
                        nq_next[idx_reg] = -$signed({1'b0, ds_result});
                    end else begin
                        nq_next[idx_reg] = $signed({1'b0, ds_result});
                    end
                    if (idx_reg == 2'd3) begin
                        state_next = ret_reg;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_N_DIV;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg  <= '0;
            target_pos_reg <= '0;
            start_ori_reg  <= mjpi_pkg::RST_ORI;
            target_ori_reg <= mjpi_pkg::RST_ORI;
            step_int_reg   <= mjpi_pkg::RST_STEP_INT;
            horiz_rcp_reg  <= mjpi_pkg::RST_HORIZ_RCP;
            step_cnt_reg   <= mjpi_pkg::RST_STEP_CNT;
            mode_reg       <= mjpi_pkg::RST_MODE;
        end else if (cfg_valid) begin
            case (cfg_index)
                mjpi_pkg::CFG_START_POS:  start_pos_reg  <= cfg_data[59:0];
                mjpi_pkg::CFG_TARGET_POS: target_pos_reg <= cfg_data[59:0];
                mjpi_pkg::CFG_START_ORI:  start_ori_reg  <= cfg_data;
                mjpi_pkg::CFG_TARGET_ORI: target_ori_reg <= cfg_data;
                mjpi_pkg::CFG_STEP_INT:   step_int_reg   <= cfg_data[19:0];
                mjpi_pkg::CFG_HORIZ_RCP:  horiz_rcp_reg  <= cfg_data[31:0];
                mjpi_pkg::CFG_STEP_CNT:   step_cnt_reg   <= cfg_data[5:0];
                mjpi_pkg::CFG_MODE:       mode_reg       <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ret_reg          <= ST_IDLE;
            origin_reg       <= '0;
            origin_valid_reg <= 1'b0;
            k_reg            <= '0;
            n_reg            <= '0;
        end else begin
            state_reg        <= state_next;
            ret_reg          <= ret_next;
            origin_reg       <= origin_next;
            origin_valid_reg <= origin_valid_next;
            k_reg            <= k_next;
            n_reg            <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        step_reg <= step_next;
        tk_reg   <= tk_next;
        tau_reg  <= tau_next;
        t2_reg   <= t2_next;
        s_reg    <= s_next;
        dot_reg  <= dot_next;
        acc_reg  <= acc_next;
        nrm_reg  <= nrm_next;
        nv_reg   <= nv_next;
        nq_reg   <= nq_next;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        pos_reg  <= pos_next;
        qo_reg   <= qo_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_EMIT);
    assign cfg_ready     = 1'b1;
    assign m_sample_time = tk_reg[31:0];
    assign m_pos_x       = pos_reg[0];
    assign m_pos_y       = pos_reg[1];
    assign m_pos_z       = pos_reg[2];
    assign m_quat_w      = qo_reg[0];
    assign m_quat_x      = qo_reg[1];
    assign m_quat_y      = qo_reg[2];
    assign m_quat_z      = qo_reg[3];
    assign m_last_pose   = (k_reg == n_reg);

`include "min_jerk_pose_interpolator_assert.svh"

    `MJPI_ASSERT_SAME(a_emit_blocks_input, m_valid, !s_ready)
    `MJPI_ASSERT_NEXT(a_accept_goes_busy, s_valid && s_ready, !s_ready)
    `MJPI_ASSERT_NEXT(a_last_returns_idle, m_valid && m_ready && m_last_pose, s_ready)
    `MJPI_ASSERT_NEXT(a_pose_advances, m_valid && m_ready && !m_last_pose, !m_valid)

endmodule
